### src/cpu8_alu_with_bcd_assert.svh
// assertion macros used by the alu top file
`ifndef CPU8_ALU_WITH_BCD_ASSERT_SVH
`define CPU8_ALU_WITH_BCD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define C8ALU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alu check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define C8ALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alu check failed: next-cycle implication");

`endif

### src/c8alu_pkg.sv
// ----------------------------------------------------------------------------
// c8alu_pkg
// types, op codes and stream layout of the 8-bit alu with bcd arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

package c8alu_pkg;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned OutWidth = 16;

  typedef enum logic [4:0] {
    OP_OR     = 5'd0,
    OP_AND    = 5'd1,
    OP_XOR    = 5'd2,
    OP_ADC    = 5'd3,
    OP_SBC    = 5'd4,
    OP_CMP    = 5'd5,
    OP_BIT    = 5'd6,
    OP_BITIMM = 5'd7,
    OP_ASL    = 5'd8,
    OP_LSR    = 5'd9,
    OP_ROL    = 5'd10,
    OP_ROR    = 5'd11,
    OP_INC    = 5'd12,
    OP_DEC    = 5'd13,
    OP_TSB    = 5'd14,
    OP_TRB    = 5'd15,
    OP_RMB    = 5'd16,
    OP_SMB    = 5'd17,
    OP_LOAD   = 5'd18
  } op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic [4:0] op;
    logic [7:0] reg_value;
    logic [7:0] mem_value;
    logic [2:0] bit_index;
    logic       decimal_mode;
    flags_t     flags;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result_byte;
    flags_t     flags;
  } alu_rsp_t;

  function automatic alu_req_t unpack_req(logic [InWidth-1:0] d);
    alu_req_t r;
    r.op           = d[4:0];
    r.reg_value    = d[12:5];
    r.mem_value    = d[20:13];
    r.bit_index    = d[23:21];
    r.decimal_mode = d[24];
    r.flags.c      = d[25];
    r.flags.n      = d[26];
    r.flags.z      = d[27];
    r.flags.v      = d[28];
    return r;
  endfunction

  function automatic logic [OutWidth-1:0] pack_rsp(alu_rsp_t r);
    return {4'b0, r.flags.v, r.flags.c, r.flags.z, r.flags.n, r.result_byte};
  endfunction

endpackage

`default_nettype wire

### src/c8alu_bcd.sv
// ----------------------------------------------------------------------------
// c8alu_bcd
// decimal add and subtract of two packed-digit bytes, digit by digit
// ----------------------------------------------------------------------------
`default_nettype none

module c8alu_bcd (
  input  logic       sub_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic       c_i,
  output logic [7:0] sum_o,
  output logic       c_o
);

  // add path: digit sums can exceed 15, keep 5 bits
  logic [4:0] add_lo_raw, add_lo, add_hi_raw, add_hi;
  logic       add_c_lo, add_c_hi;
  logic [7:0] add_sum;

  // subtract path: digit differences taken mod 256
  logic [7:0] sub_lo_raw, sub_lo, sub_hi_raw, sub_hi;
  logic       sub_c_lo, sub_c_hi;

  always_comb begin
    add_lo_raw = {1'b0, a_i[3:0]} + {1'b0, b_i[3:0]} + {4'b0, c_i};
    add_c_lo   = (add_lo_raw >= 5'd10);
    add_lo     = add_c_lo ? add_lo_raw - 5'd10 : add_lo_raw;
    add_hi_raw = {1'b0, a_i[7:4]} + {1'b0, b_i[7:4]} + {4'b0, add_c_lo};
    add_c_hi   = (add_hi_raw > 5'd9);
    add_hi     = add_c_hi ? add_hi_raw - 5'd10 : add_hi_raw;
    add_sum    = {add_hi[3:0], 4'b0} + {3'b0, add_lo};

    sub_lo_raw = {4'b0, a_i[3:0]} - {4'b0, b_i[3:0]} - {7'b0, ~c_i};
    sub_c_lo   = ~sub_lo_raw[7];
    sub_lo     = sub_c_lo ? sub_lo_raw : sub_lo_raw - 8'd6;
    sub_hi_raw = {4'b0, a_i[7:4]} - {4'b0, b_i[7:4]} - {7'b0, ~sub_c_lo};
    sub_c_hi   = ~sub_hi_raw[7];
    sub_hi     = sub_c_hi ? sub_hi_raw : sub_hi_raw - 8'd6;

    if (sub_i) begin
      sum_o = {sub_hi[3:0], sub_lo[3:0]};
      c_o   = sub_c_hi;
    end else begin
      sum_o = add_sum;
      c_o   = add_c_hi;
    end
  end

endmodule

`default_nettype wire

### src/c8alu_exec.sv
// ----------------------------------------------------------------------------
// c8alu_exec
// operation decode, result byte and flag update for one request
// ----------------------------------------------------------------------------
`default_nettype none

module c8alu_exec (
  input  c8alu_pkg::alu_req_t req_i,
  output c8alu_pkg::alu_rsp_t rsp_o
);
  import c8alu_pkg::*;

  logic [7:0] a, b;
  logic       cin;
  logic [8:0] bin_sum;
  logic [7:0] bin_b;
  logic       is_sbc;
  logic [7:0] bcd_sum;
  logic       bcd_c;
  logic [7:0] cmp_diff;
  logic [7:0] bit_mask;
  logic       and_zero;
  logic [7:0] r;
  flags_t     f;
  logic       set_nz;

  assign a      = req_i.reg_value;
  assign b      = req_i.mem_value;
  assign cin    = req_i.flags.c;
  assign is_sbc = (req_i.op == OP_SBC);

  // binary sbc is an add of the inverted operand
  assign bin_b   = is_sbc ? ~b : b;
  assign bin_sum = {1'b0, a} + {1'b0, bin_b} + {8'b0, cin};

  assign cmp_diff = a - b;
  assign bit_mask = 8'd1 << req_i.bit_index;
  assign and_zero = ((a & b) == 8'd0);

  c8alu_bcd u_bcd (
    .sub_i (is_sbc),
    .a_i   (a),
    .b_i   (b),
    .c_i   (cin),
    .sum_o (bcd_sum),
    .c_o   (bcd_c)
  );

  always_comb begin
    r      = a;
    f      = req_i.flags;
    set_nz = 1'b0;
    case (req_i.op)
      OP_OR:  begin r = a | b; set_nz = 1'b1; end
      OP_AND: begin r = a & b; set_nz = 1'b1; end
      OP_XOR: begin r = a ^ b; set_nz = 1'b1; end
      OP_ADC, OP_SBC: begin
        set_nz = 1'b1;
        if (req_i.decimal_mode) begin
          r   = bcd_sum;
          f.c = bcd_c;
          f.v = bcd_c;
        end else begin
          r   = bin_sum[7:0];
          f.c = bin_sum[8];
          f.v = ~(a[7] ^ bin_b[7]) & (a[7] ^ bin_sum[7]);
        end
      end
      OP_CMP: begin
        f.c = (a >= b);
        f.n = cmp_diff[7];
        f.z = (cmp_diff == 8'd0);
      end
      OP_BIT: begin
        f.n = b[7];
        f.v = b[6];
        f.z = and_zero;
      end
      OP_BITIMM: f.z = and_zero;
      OP_ASL: begin r = {b[6:0], 1'b0}; f.c = b[7]; set_nz = 1'b1; end
      OP_LSR: begin r = {1'b0, b[7:1]}; f.c = b[0]; set_nz = 1'b1; end
      OP_ROL: begin r = {b[6:0], cin};  f.c = b[7]; set_nz = 1'b1; end
      OP_ROR: begin r = {cin, b[7:1]};  f.c = b[0]; set_nz = 1'b1; end
      OP_INC: begin r = b + 8'd1; set_nz = 1'b1; end
      OP_DEC: begin r = b - 8'd1; set_nz = 1'b1; end
      OP_TSB: begin r = b | a;  f.z = and_zero; end
      OP_TRB: begin r = b & ~a; f.z = and_zero; end
      OP_RMB: r = b & ~bit_mask;
      OP_SMB: r = b | bit_mask;
      OP_LOAD: begin r = b; set_nz = 1'b1; end
      default: r = a;
    endcase
    if (set_nz) begin
      f.n = r[7];
      f.z = (r == 8'd0);
    end
    rsp_o.result_byte = r;
    rsp_o.flags       = f;
  end

endmodule

`default_nettype wire

### src/cpu8_alu_with_bcd.sv
// ----------------------------------------------------------------------------
// cpu8_alu_with_bcd
// 8-bit processor alu with binary and bcd add/subtract, streaming wrapper
// ----------------------------------------------------------------------------
// usage:
//   one request word in on s_axis, one response word out on m_axis.
//   s_axis_tdata bits: op_code[4:0], reg_value[12:5], mem_value[20:13],
//   bit_index[23:21], decimal_mode[24], carry_in[25], neg_in[26],
//   zero_in[27], ovf_in[28], zero fill above.
//   m_axis_tdata bits: result_byte[7:0], neg_out[8], zero_out[9],
//   carry_out[10], ovf_out[11], zero fill above.
//   a word taken into the input register passes through one level of alu
//   logic and shows on m_axis once the result register takes it.
//   throughput: one word per cycle, limited only by the output side.
//   while the receiver stalls, the result register holds its word and the
//   input register can still take one more word; after that s_axis_tready
//   drops until the output drains.
//   reset clears both valid flags; no state survives between words.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8_alu_with_bcd (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [c8alu_pkg::InWidth-1:0]     s_axis_tdata,  // op, reg, mem, bit, dec, c, n, z, v
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [c8alu_pkg::OutWidth-1:0]    m_axis_tdata   // result, n, z, c, v
);
  import c8alu_pkg::*;

  logic     in_valid_q, in_valid_d;
  alu_req_t in_req_q;
  logic     out_valid_q, out_valid_d;
  alu_rsp_t out_rsp_q;
  alu_rsp_t exec_rsp;
  logic     out_load;
  logic     in_load;

  // result register frees up when empty or being drained this cycle
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_load || (in_valid_q && !out_load);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  c8alu_exec u_exec (
    .req_i (in_req_q),
    .rsp_o (exec_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_req_q <= unpack_req(s_axis_tdata);
    end
    if (out_load) begin
      out_rsp_q <= exec_rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pack_rsp(out_rsp_q);

  `include "cpu8_alu_with_bcd_assert.svh"

  // a word in the input stage moves to the output once it has room
  `C8ALU_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, out_load, m_axis_tvalid)
  // an empty output stage never blocks the input side
  `C8ALU_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, s_axis_tready)
  // bit set and reset leave all flags alone
  `C8ALU_ASSERT_NOW(a_rmb_smb_flags, clk_i, rst_ni,
    in_valid_q && (in_req_q.op == OP_RMB || in_req_q.op == OP_SMB),
    exec_rsp.flags == in_req_q.flags)

endmodule

`default_nettype wire

### dv/cpu8_alu_with_bcd_test.sv
// ----------------------------------------------------------------------------
// cpu8_alu_with_bcd_test
// self-checking bench for the 8-bit alu with bcd add/subtract: a directed
// pass over every op and the corner cases, then random words under changing
// idle patterns and one long output stall, each result checked against a
// behavioral alu model
// ----------------------------------------------------------------------------
module cpu8_alu_with_bcd_test;
  timeunit 1ns;
  timeprecision 1ps;

  import c8alu_pkg::*;

  localparam int unsigned RandWords = 500;
  localparam int unsigned HoldCycles = 64;
  localparam logic [4:0] OpUnusedLo = 5'd19;
  localparam logic [4:0] OpUnusedHi = 5'd31;

  // request word, lowest field last
  typedef struct packed {
    logic [2:0] pad;
    logic       v;
    logic       z;
    logic       n;
    logic       c;
    logic       dec_mode;
    logic [2:0] bit_idx;
    logic [7:0] mem_val;
    logic [7:0] reg_val;
    logic [4:0] op;
  } alu_word_t;

  // response word, lowest field last
  typedef struct packed {
    logic [3:0] pad;
    logic       v;
    logic       c;
    logic       z;
    logic       n;
    logic [7:0] res_byte;
  } alu_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;  // op, reg, mem, bit, dec, c, n, z, v
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;       // result, n, z, c, v

  alu_word_t   pending_words[$];
  alu_result_t expected_results[$];
  int unsigned total_words = 0;
  int unsigned accepted_words = 0;
  int unsigned fail_count = 0;
  logic        word_taken = 1'b0;
  logic        rx_hold = 1'b0;

  cpu8_alu_with_bcd dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic alu_result_t alu_predict(alu_word_t w);
    alu_result_t y;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  nb;
    logic [7:0]  diff;
    logic        upd_nz;
    int          lo;
    int          hi;
    int          sum;
    int          cy;
    a = w.reg_val;
    b = w.mem_val;
    nb = ~b;
    upd_nz = 1'b1;
    y = '0;
    y.res_byte = a;
    y.n = w.n;
    y.z = w.z;
    y.c = w.c;
    y.v = w.v;
    case (w.op)
      OP_OR:  y.res_byte = a | b;
      OP_AND: y.res_byte = a & b;
      OP_XOR: y.res_byte = a ^ b;
      OP_ADC: begin
        if (w.dec_mode) begin
          lo = int'(a[3:0]) + int'(b[3:0]) + int'(w.c);
          cy = 0;
          if (lo >= 10) begin
            cy = 1;
            lo -= 10;
          end
          hi = int'(a[7:4]) + int'(b[7:4]) + cy;
          cy = 0;
          if (hi > 9) begin
            cy = 1;
            hi -= 10;
          end
          y.res_byte = 8'((hi << 4) + lo);
          y.c = cy[0];
          y.v = cy[0];
        end else begin
          sum = int'(a) + int'(b) + int'(w.c);
          y.res_byte = sum[7:0];
          y.c = sum[8];
          y.v = ~(a[7] ^ b[7]) & (a[7] ^ y.res_byte[7]);
        end
      end
      OP_SBC: begin
        if (w.dec_mode) begin
          // the low digit's borrow feeds the high digit, negative digits get 6 taken off
          lo = (int'(a[3:0]) - int'(b[3:0]) - (1 - int'(w.c))) & 255;
          cy = 1;
          if (lo & 128) begin
            cy = 0;
            lo = (lo - 6) & 255;
          end
          hi = (int'(a[7:4]) - int'(b[7:4]) - (1 - cy)) & 255;
          cy = 1;
          if (hi & 128) begin
            cy = 0;
            hi = (hi - 6) & 255;
          end
          y.res_byte = 8'((hi << 4) + (lo & 15));
          y.c = cy[0];
          y.v = cy[0];
        end else begin
          sum = int'(a) + int'(nb) + int'(w.c);
          y.res_byte = sum[7:0];
          y.c = sum[8];
          y.v = (a[7] ^ b[7]) & (a[7] ^ y.res_byte[7]);
        end
      end
      OP_CMP: begin
        diff = a - b;
        y.c = (a >= b);
        y.n = diff[7];
        y.z = (diff == 8'h00);
        upd_nz = 1'b0;
      end
      OP_BIT: begin
        y.v = b[6];
        y.n = b[7];
        y.z = ((a & b) == 8'h00);
        upd_nz = 1'b0;
      end
      OP_BITIMM: begin
        y.z = ((a & b) == 8'h00);
        upd_nz = 1'b0;
      end
      OP_ASL: begin
        y.res_byte = {b[6:0], 1'b0};
        y.c = b[7];
      end
      OP_LSR: begin
        y.res_byte = {1'b0, b[7:1]};
        y.c = b[0];
      end
      OP_ROL: begin
        y.res_byte = {b[6:0], w.c};
        y.c = b[7];
      end
      OP_ROR: begin
        y.res_byte = {w.c, b[7:1]};
        y.c = b[0];
      end
      OP_INC: y.res_byte = b + 8'd1;
      OP_DEC: y.res_byte = b - 8'd1;
      OP_TSB: begin
        y.z = ((a & b) == 8'h00);
        y.res_byte = b | a;
        upd_nz = 1'b0;
      end
      OP_TRB: begin
        y.z = ((a & b) == 8'h00);
        y.res_byte = b & ~a;
        upd_nz = 1'b0;
      end
      OP_RMB: begin
        y.res_byte = b & ~(8'd1 << w.bit_idx);
        upd_nz = 1'b0;
      end
      OP_SMB: begin
        y.res_byte = b | (8'd1 << w.bit_idx);
        upd_nz = 1'b0;
      end
      OP_LOAD: y.res_byte = b;
      default: upd_nz = 1'b0;  // unused op: register and flags pass through
    endcase
    if (upd_nz) begin
      y.n = y.res_byte[7];
      y.z = (y.res_byte == 8'h00);
    end
    return y;
  endfunction

  function automatic alu_word_t random_word(logic [4:0] op);
    alu_word_t w;
    w = '0;
    w.op = op;
    w.reg_val = 8'($urandom);
    w.mem_val = 8'($urandom);
    w.bit_idx = 3'($urandom);
    w.dec_mode = 1'($urandom);
    w.c = 1'($urandom);
    w.n = 1'($urandom);
    w.z = 1'($urandom);
    w.v = 1'($urandom);
    return w;
  endfunction

  function automatic logic [7:0] random_bcd();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    alu_word_t w;
    logic [4:0] op;
    for (int k = OP_OR; k <= OP_LOAD; k++) begin
      w = random_word(5'(k));
      if (k[0]) begin
        w.reg_val = 8'hFF;
        w.mem_val = 8'h00;
      end
      pending_words.push_back(w);
    end
    w = random_word(OpUnusedHi);
    pending_words.push_back(w);
    // bcd add with carry out of the tens digit
    w = random_word(OP_ADC);
    w.dec_mode = 1'b1;
    w.reg_val = 8'h99;
    w.mem_val = 8'h01;
    w.c = 1'b0;
    pending_words.push_back(w);
    // bcd subtract that borrows through both digits
    w = random_word(OP_SBC);
    w.dec_mode = 1'b1;
    w.reg_val = 8'h00;
    w.mem_val = 8'h01;
    w.c = 1'b1;
    pending_words.push_back(w);
    // signed overflow on binary add
    w = random_word(OP_ADC);
    w.dec_mode = 1'b0;
    w.reg_val = 8'h7F;
    w.mem_val = 8'h01;
    w.c = 1'b0;
    pending_words.push_back(w);
    // increment wraps to zero
    w = random_word(OP_INC);
    w.mem_val = 8'hFF;
    pending_words.push_back(w);

    for (int unsigned i = 0; i < RandWords; i++) begin
      if ($urandom_range(15) == 0) begin
        op = 5'($urandom_range(OpUnusedHi, OpUnusedLo));
      end else begin
        op = 5'($urandom_range(OP_LOAD, OP_OR));
      end
      w = random_word(op);
      // mostly well-formed bcd operands for decimal add/subtract
      if (w.dec_mode && (op == OP_ADC || op == OP_SBC) && $urandom_range(3) != 0) begin
        w.reg_val = random_bcd();
        w.mem_val = random_bcd();
      end
      pending_words.push_back(w);
    end
    total_words = pending_words.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_words < total_words || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // long output stall while the sender keeps offering words
  initial begin
    @(posedge clk_i);
    while (accepted_words < (total_words * 5) / 6) begin
      @(posedge clk_i);
    end
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(negedge clk_i) begin : drive
    int unsigned send_idle;
    int unsigned recv_idle;
    if (accepted_words < total_words / 3) begin
      send_idle = 27;
      recv_idle = 82;
    end else if (accepted_words < (total_words * 2) / 3) begin
      send_idle = 82;
      recv_idle = 27;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (rst_ni) begin
      if (!s_axis_tvalid || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_words.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : observe
    alu_result_t got;
    alu_result_t want;
    word_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (word_taken) begin
      expected_results.push_back(alu_predict(alu_word_t'(s_axis_tdata)));
      accepted_words++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = alu_result_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        $error("unexpected word on output: %04h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_byte", want.res_byte, got.res_byte);
        check_field("neg_out", want.n, got.n);
        check_field("zero_out", want.z, got.z);
        check_field("carry_out", want.c, got.c);
        check_field("ovf_out", want.v, got.v);
      end
    end
  end

endmodule
